@@ rtl/core/b64c_pkg.sv @@
`timescale 1ns / 1ps
// Package for the base64 codec: alphabet mapping functions, result type and
// character constants. No dependencies.
package b64c_pkg;

    localparam int unsigned MAX_RES   = 4;   // results per input beat, at most
    localparam int unsigned GROUP_W   = 18;  // gathered bits of one group
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;  // '+'
    localparam logic [7:0] SLASH_CHAR = 8'h2F;  // '/'
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] DIGIT_0    = 8'h30;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } t_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } t_result;

    typedef struct packed {
        logic       valid;   // member of the alphabet, '=' included
        logic       pad;     // the '=' character
        logic [5:0] value;
    } t_dec;

    // 6-bit value to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = UPPER_A + {2'b00, v};
        end else if (v < 6'd52) begin
            c = LOWER_A + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = DIGIT_0 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = PLUS_CHAR;
        end else begin
            c = SLASH_CHAR;
        end
        return c;
    endfunction

    // alphabet character to 6-bit value
    function automatic t_dec dec_char(input logic [7:0] c);
        t_dec d;
        d = '{valid: 1'b1, pad: 1'b0, value: 6'd0};
        if (c >= UPPER_A && c <= UPPER_A + 8'd25) begin
            d.value = 6'(c - UPPER_A);
        end else if (c >= LOWER_A && c <= LOWER_A + 8'd25) begin
            d.value = 6'(c - LOWER_A + 8'd26);
        end else if (c >= DIGIT_0 && c <= DIGIT_0 + 8'd9) begin
            d.value = 6'(c - DIGIT_0 + 8'd52);
        end else if (c == PLUS_CHAR) begin
            d.value = 6'd62;
        end else if (c == SLASH_CHAR) begin
            d.value = 6'd63;
        end else if (c == PAD_CHAR) begin
            d.pad = 1'b1;
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

@@ rtl/core/base64_codec.sv @@
`timescale 1ns / 1ps
// Base64 codec top level: streaming encoder/decoder with an APB mode register.
// Depends on b64c_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | sink      | i_in_valid / o_in_ready   | i_in_byte, i_in_last
//  out     | source    | o_out_valid / i_out_ready | o_out_byte, o_out_last, o_bad_input
//  cfg     | APB slave | psel, penable, pready     | paddr, pwdata, prdata
//
// Each input beat is decoded combinationally and written into a result buffer of up to four beats,
// which drains one beat per cycle while i_out_ready is high. The drain of that buffer sets
// the rate of input beats: in encode mode every third byte, and the last, yields four results;
// in decode mode a completed group yields up to three and a bad character one error beat.
// A new beat is taken in the cycle the last buffered result leaves.
// Reset is synchronous; it clears the mode, the group and the error latch.
module base64_codec (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_in_byte,
    input  logic                               i_in_last,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [7:0]                         o_out_byte,
    output logic                               o_out_last,
    output logic                               o_bad_input,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [b64c_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [b64c_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [b64c_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import b64c_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_RES);
    localparam int unsigned CNT_W = $clog2(MAX_RES + 1);

    t_mode               r_mode;
    logic [GROUP_W-1:0]  r_group, n_group;
    logic [1:0]          r_gcnt, n_gcnt;
    logic                r_pad, n_pad;
    logic                r_err, n_err;

    t_result             r_res [MAX_RES];
    t_result             n_res [MAX_RES];
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [IDX_W-1:0]    r_idx;

    logic                cfg_wr;
    logic                in_acc;
    logic                out_acc;
    t_dec                dec;
    logic [23:0]         word;

    assign pready  = 1'b1;
    assign prdata  = {{(CFG_DATA_W-1){1'b0}}, r_mode};
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[CFG_ADDR_W-1] == 1'b0);

    assign o_out_valid = (r_cnt != '0);
    assign o_out_byte  = r_res[r_idx].data;
    assign o_out_last  = r_res[r_idx].last;
    assign o_bad_input = r_res[r_idx].bad;
    assign out_acc     = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_cnt == '0) || (r_cnt == CNT_W'(1) && i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;

    assign dec = dec_char(i_in_byte);

    always_comb begin
        n_group = r_group;
        n_gcnt  = r_gcnt;
        n_pad   = r_pad;
        n_err   = r_err;
        n_cnt   = '0;
        word    = '0;
        for (int k = 0; k < MAX_RES; k++) begin
            n_res[k] = '{data: 8'h00, last: 1'b0, bad: 1'b0};
        end

        if (r_err) begin
            // drop beats until the end of the message
            if (i_in_last) begin
                n_err = 1'b0;
            end
        end else if (r_mode == MODE_DECODE) begin
            if (!dec.valid || (dec.pad && r_gcnt < 2'd2) || (r_gcnt < 2'd3 && i_in_last)) begin
                n_group  = '0;
                n_gcnt   = '0;
                n_pad    = 1'b0;
                n_err    = !i_in_last;
                n_res[0] = '{data: 8'h00, last: i_in_last, bad: 1'b1};
                n_cnt    = CNT_W'(1);
            end else if (r_gcnt < 2'd3) begin
                n_group = {r_group[GROUP_W-7:0], (dec.pad ? 6'd0 : dec.value)};
                n_gcnt  = r_gcnt + 2'd1;
                n_pad   = r_pad || dec.pad;
            end else begin
                word     = {r_group, (dec.pad ? 6'd0 : dec.value)};
                n_group  = '0;
                n_gcnt   = '0;
                n_pad    = 1'b0;
                n_res[0] = '{data: word[23:16], last: 1'b0, bad: 1'b0};
                n_res[1] = '{data: word[15:8],  last: 1'b0, bad: 1'b0};
                n_res[2] = '{data: word[7:0],   last: i_in_last, bad: 1'b0};
                if (r_pad) begin
                    n_res[0].last = i_in_last;
                    n_cnt = CNT_W'(1);
                end else if (dec.pad) begin
                    n_res[1].last = i_in_last;
                    n_cnt = CNT_W'(2);
                end else begin
                    n_cnt = CNT_W'(3);
                end
            end
        end else begin
            if (r_gcnt >= 2'd2) begin
                word = {r_group[15:0], i_in_byte};
            end else if (r_gcnt == 2'd1) begin
                word = {r_group[7:0], i_in_byte, 8'h00};
            end else begin
                word = {i_in_byte, 16'h0000};
            end
            n_res[0] = '{data: enc_char(word[23:18]), last: 1'b0, bad: 1'b0};
            n_res[1] = '{data: enc_char(word[17:12]), last: 1'b0, bad: 1'b0};
            n_res[2] = '{data: enc_char(word[11:6]),  last: 1'b0, bad: 1'b0};
            n_res[3] = '{data: enc_char(word[5:0]),   last: i_in_last, bad: 1'b0};
            if (r_gcnt >= 2'd2 || i_in_last) begin
                // group complete or message end: pad a short final group with '='
                if (r_gcnt == 2'd0) begin
                    n_res[2].data = PAD_CHAR;
                end
                if (r_gcnt < 2'd2) begin
                    n_res[3].data = PAD_CHAR;
                end
                n_group = '0;
                n_gcnt  = '0;
                n_cnt   = CNT_W'(4);
            end else begin
                n_group = {r_group[GROUP_W-9:0], i_in_byte};
                n_gcnt  = r_gcnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ENCODE;
            r_group <= '0;
            r_gcnt  <= '0;
            r_pad   <= 1'b0;
            r_err   <= 1'b0;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            if (cfg_wr) begin
                // mode write restarts the codec
                r_mode  <= t_mode'(pwdata[0]);
                r_group <= '0;
                r_gcnt  <= '0;
                r_pad   <= 1'b0;
                r_err   <= 1'b0;
            end else if (in_acc) begin
                r_group <= n_group;
                r_gcnt  <= n_gcnt;
                r_pad   <= n_pad;
                r_err   <= n_err;
            end

            if (in_acc) begin
                r_cnt <= n_cnt;
                r_idx <= '0;
            end else if (out_acc) begin
                r_cnt <= r_cnt - CNT_W'(1);
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int k = 0; k < MAX_RES; k++) begin
                r_res[k] <= n_res[k];
            end
        end
    end

endmodule

@@ rtl/core/b64c_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the base64 codec, bound to the top level.
// Depends on b64c_pkg and base64_codec.
module b64c_props (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [7:0]                         o_out_byte,
    input logic                               o_bad_input,
    input logic [b64c_pkg::CFG_DATA_W-1:0]    prdata,
    input logic                               pready
);

    // hold a stalled beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_input |-> o_out_byte == 8'h00)
        else $error("error beat carries data");

    a_enc_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !prdata[0] |-> !o_bad_input)
        else $error("error beat in encode mode");

    a_stall_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready && pready)
        else $error("input taken while results are stalled");

endmodule

bind base64_codec b64c_props u_b64c_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_byte  (o_out_byte),
    .o_bad_input (o_bad_input),
    .prdata      (prdata),
    .pready      (pready)
);

@@ test/b64c_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for base64_codec: watches the byte, result and register ports,
// predicts every result beat and compares it field by field. Depends on b64c_pkg.
module b64c_checker #(
    parameter logic [b64c_pkg::CFG_ADDR_W-1:0] MODE_ADDR = '0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_in_last,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [7:0]                      i_out_byte,
    input  logic                            i_out_last,
    input  logic                            i_bad_input,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [b64c_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  logic [b64c_pkg::CFG_DATA_W-1:0] i_pwdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    import b64c_pkg::*;

    localparam int SYM_PAD = 64;
    localparam int SYM_BAD = -1;

    logic [7:0]  sym_of [64];
    int          val_of [256];

    t_mode       cur_mode;
    logic [17:0] grp_bits;
    logic [1:0]  grp_cnt;
    logic        drop_to_last;
    logic        pad_at_two;
    t_result     due_beats [$];
    int          fails;

    assign o_fail_count = fails;

    initial begin : build_tables
        string abc;
        abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        foreach (val_of[i]) val_of[i] = SYM_BAD;
        for (int i = 0; i < 64; i++) begin
            sym_of[i] = abc[i];
            val_of[abc[i]] = i;
        end
        val_of[PAD_CHAR] = SYM_PAD;
    end

    function automatic void owe_beat(input logic [7:0] d, input logic l, input logic b);
        t_result r;
        r.data = d;
        r.last = l;
        r.bad  = b;
        due_beats.push_back(r);
    endfunction

    function automatic void clear_group();
        grp_bits   = '0;
        grp_cnt    = '0;
        pad_at_two = 1'b0;
    endfunction

    // a bad beat ends the group; unless it closes the message, drop up to the next last
    function automatic void flag_error(input logic l);
        clear_group();
        drop_to_last = !l;
        owe_beat(8'h00, l, 1'b1);
    endfunction

    function automatic void advance_codec(input logic [7:0] b, input logic l);
        int          v;
        int          n;
        logic [23:0] w;
        if (drop_to_last) begin
            if (l) drop_to_last = 1'b0;
        end else if (cur_mode == MODE_ENCODE) begin
            if (grp_cnt >= 2'd2) begin
                w = {grp_bits[15:0], b};
                owe_beat(sym_of[w[23:18]], 1'b0, 1'b0);
                owe_beat(sym_of[w[17:12]], 1'b0, 1'b0);
                owe_beat(sym_of[w[11:6]], 1'b0, 1'b0);
                owe_beat(sym_of[w[5:0]], l, 1'b0);
                clear_group();
            end else if (!l) begin
                grp_bits = {grp_bits[9:0], b};
                grp_cnt  = grp_cnt + 2'd1;
            end else begin
                // short tail: pad to four characters
                w = (grp_cnt == 2'd0) ? {b, 16'h0000} : {grp_bits[7:0], b, 8'h00};
                owe_beat(sym_of[w[23:18]], 1'b0, 1'b0);
                owe_beat(sym_of[w[17:12]], 1'b0, 1'b0);
                owe_beat((grp_cnt == 2'd0) ? PAD_CHAR : sym_of[w[11:6]], 1'b0, 1'b0);
                owe_beat(PAD_CHAR, 1'b1, 1'b0);
                clear_group();
            end
        end else begin
            v = val_of[b];
            if (v == SYM_BAD || (v == SYM_PAD && grp_cnt < 2'd2)) begin
                flag_error(l);
            end else if (grp_cnt < 2'd3) begin
                if (l) begin
                    flag_error(1'b1);
                end else begin
                    if (v == SYM_PAD) begin
                        pad_at_two = 1'b1;
                        v = 0;
                    end
                    grp_bits = {grp_bits[11:0], 6'(v)};
                    grp_cnt  = grp_cnt + 2'd1;
                end
            end else begin
                // a pad at position two wins over whatever sits at position three
                n = pad_at_two ? 1 : ((v == SYM_PAD) ? 2 : 3);
                if (v == SYM_PAD) v = 0;
                w = {grp_bits, 6'(v)};
                owe_beat(w[23:16], (n == 1) ? l : 1'b0, 1'b0);
                if (n >= 2) owe_beat(w[15:8], (n == 2) ? l : 1'b0, 1'b0);
                if (n == 3) owe_beat(w[7:0], l, 1'b0);
                clear_group();
            end
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cur_mode     = MODE_ENCODE;
            drop_to_last = 1'b0;
            fails        = 0;
            clear_group();
            due_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.data = i_out_byte;
                got.last = i_out_last;
                got.bad  = i_bad_input;
                if (due_beats.size() == 0) begin
                    $error("unexpected result beat: out_byte %0h", got.data);
                    fails++;
                end else begin
                    want = due_beats.pop_front();
                    if (got.data !== want.data) begin
                        $error("out_byte: expected %0h, got %0h", want.data, got.data);
                        fails++;
                    end
                    if (got.last !== want.last) begin
                        $error("out_last: expected %0b, got %0b", want.last, got.last);
                        fails++;
                    end
                    if (got.bad !== want.bad) begin
                        $error("bad_input: expected %0b, got %0b", want.bad, got.bad);
                        fails++;
                    end
                end
            end
            // a mode write restarts the codec
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == MODE_ADDR) begin
                cur_mode     = t_mode'(i_pwdata[0]);
                drop_to_last = 1'b0;
                clear_group();
            end
            if (i_in_valid && i_in_ready) advance_codec(i_in_byte, i_in_last);
        end
        o_pending <= due_beats.size();
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Top of the base64_codec testbench: clock, reset, byte and register stimulus,
// watchdog and verdict. Depends on b64c_pkg, base64_codec and b64c_checker.
module tb;
    import b64c_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] MODE_ADDR = '0;
    localparam int RANDOM_ITEMS   = 350;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum int {
        GRP_FULL,
        GRP_TWO_PADS,
        GRP_ONE_PAD,
        GRP_PAD_THEN_SYM
    } t_grp;

    typedef enum int {
        FLAW_CHAR,
        FLAW_CUT,
        FLAW_PAD
    } t_flaw;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            in_byte = '0;
    logic                  in_last = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            out_byte;
    logic                  out_last;
    logic                  bad_input;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;

    logic                  tx_calm = 1'b0;
    logic                  rx_calm = 1'b0;
    logic                  msg_open = 1'b0;
    logic [7:0]            msg_q [$];
    int unsigned           rx_wait = 0;
    int unsigned           quiet = 0;
    string                 b64_abc =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    base64_codec dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_byte   (in_byte),
        .i_in_last   (in_last),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_byte  (out_byte),
        .o_out_last  (out_last),
        .o_bad_input (bad_input),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    b64c_checker #(.MODE_ADDR(MODE_ADDR)) scb (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_byte    (in_byte),
        .i_in_last    (in_last),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_byte   (out_byte),
        .i_out_last   (out_last),
        .i_bad_input  (bad_input),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side: after each beat, stall at random unless rx_calm is set
    always @(posedge clk) begin : rx_side
        int unsigned hold;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end else if (out_ready && out_valid) begin
            hold = rx_calm ? 0 : $urandom_range(0, 7);
            out_ready <= (hold == 0);
            rx_wait   <= (hold == 0) ? 0 : hold - 1;
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic l);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= l;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_msg();
        foreach (msg_q[i]) send_beat(msg_q[i], !msg_open && i == msg_q.size() - 1);
    endtask

    // drain all results, let the block settle, then write the mode register
    task automatic set_mode(input t_mode m);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= CFG_DATA_W'(m);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic void load_text(input string s);
        msg_q.delete();
        for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
        msg_open = 1'b0;
    endfunction

    function automatic logic [7:0] rand_sym();
        return b64_abc[$urandom_range(0, 63)];
    endfunction

    function automatic int make_byte_msg();
        int len;
        len = $urandom_range(1, 10);
        msg_q.delete();
        repeat (len) msg_q.push_back(8'($urandom_range(0, 255)));
        // leave some messages open so the group carries into the next one
        msg_open = ($urandom_range(0, 7) == 0);
        return len;
    endfunction

    // returns the number of characters the codec will actually act on
    function automatic int make_char_msg();
        t_grp kind;
        int   p;
        msg_q.delete();
        msg_open = 1'b0;
        repeat ($urandom_range(1, 3)) begin
            kind = ($urandom_range(0, 1) != 0) ? GRP_FULL : t_grp'($urandom_range(1, 3));
            msg_q.push_back(rand_sym());
            msg_q.push_back(rand_sym());
            case (kind)
                GRP_TWO_PADS: begin
                    msg_q.push_back(PAD_CHAR);
                    msg_q.push_back(PAD_CHAR);
                end
                GRP_ONE_PAD: begin
                    msg_q.push_back(rand_sym());
                    msg_q.push_back(PAD_CHAR);
                end
                GRP_PAD_THEN_SYM: begin
                    msg_q.push_back(PAD_CHAR);
                    msg_q.push_back(rand_sym());
                end
                default: begin
                    msg_q.push_back(rand_sym());
                    msg_q.push_back(rand_sym());
                end
            endcase
        end
        if ($urandom_range(0, 4) != 0) return msg_q.size();
        p = $urandom_range(0, msg_q.size() - 1);
        case (t_flaw'($urandom_range(0, 2)))
            FLAW_CHAR: begin
                msg_q[p] = 8'($urandom_range(0, 255));
            end
            FLAW_CUT: begin
                repeat ($urandom_range(1, 3)) void'(msg_q.pop_back());
                return msg_q.size();
            end
            default: begin
                p = p - p % 4 + $urandom_range(0, 1);
                msg_q[p] = PAD_CHAR;
            end
        endcase
        return p + 1;
    endfunction

    initial begin : stimulus
        int    sent;
        int    goal;
        t_mode mode;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // encode: full group of extremes, one-byte tail, two-byte tail
        set_mode(MODE_ENCODE);
        msg_open = 1'b0;
        msg_q = '{8'h00, 8'hFF, 8'h7F};
        send_msg();
        msg_q = '{8'hFF};
        send_msg();
        msg_q = '{8'h01, 8'hFE};
        send_msg();

        // decode: padded groups followed by more data, pad then a character,
        // bad character and misplaced pads (a lone one, and one with drop to last), truncated group
        set_mode(MODE_DECODE);
        load_text("TQ==TWE=+/09");
        send_msg();
        load_text("QU=z");
        send_msg();
        load_text("*AB");
        send_msg();
        load_text("=");
        send_msg();
        load_text("A=B");
        send_msg();
        load_text("AB");
        send_msg();

        sent = 0;
        mode = MODE_DECODE;
        while (sent < RANDOM_ITEMS) begin
            mode = (mode == MODE_ENCODE) ? MODE_DECODE : MODE_ENCODE;
            set_mode(mode);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm <= ($urandom_range(0, 3) == 0);
            goal = sent + $urandom_range(30, 80);
            while (sent < goal) begin
                if (mode == MODE_DECODE) sent += make_char_msg();
                else sent += make_byte_msg();
                send_msg();
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
